FILE: hw/rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types, constants and functions of the clamped PID controller
// Holds the sequencer codes, the configuration bundle and the term clamp.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int DivSteps    = 32;               // two quotient bits per step
   localparam int DivCntWidth = $clog2(DivSteps);

   localparam logic [31:0] Int32Max = 32'h7FFF_FFFF;
   localparam logic [31:0] Int32Min = 32'h8000_0000;
   localparam logic [63:0] LimReset = 64'h7FFF_FFFF_8000_0000;

   // register indexes, byte address is 8 * index
   localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] REG_P_LIMITS     = 3'd3;
   localparam logic [2:0] REG_ACCUM_LIMITS = 3'd4;
   localparam logic [2:0] REG_I_LIMITS     = 3'd5;
   localparam logic [2:0] REG_D_LIMITS     = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_EKI,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_INC,
      ST_INTEG,
      ST_MUL_I,
      ST_CLAMP_I,
      ST_MUL_D,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_D_ZERO,
      ST_SUM
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR,
      OP_MUL_P,
      OP_MUL_EKI,
      OP_MUL_HI,
      OP_MUL_LO,
      OP_INC,
      OP_INTEG,
      OP_MUL_I,
      OP_CLAMP_I,
      OP_MUL_D,
      OP_DIV_START,
      OP_D_FIX,
      OP_D_ZERO,
      OP_SUM
   } op_type;

   typedef struct packed {
      logic dt_zero;
      logic div_done;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
      logic [63:0]        p_lim;
      logic [63:0]        a_lim;
      logic [63:0]        i_lim;
      logic [63:0]        d_lim;
   } cfg_type;

   // below min gives min, otherwise above max gives max
   function automatic logic [31:0] clamp_lim(input logic signed [63:0] x,
                                             input logic [63:0] lim);
      logic signed [63:0] mn;
      logic signed [63:0] mx;
      mn = {{32{lim[31]}}, lim[31:0]};
      mx = {{32{lim[63]}}, lim[63:32]};
      if (x < mn) begin
         return lim[31:0];
      end else if (x > mx) begin
         return lim[63:32];
      end
      return x[31:0];
   endfunction

endpackage

FILE: hw/rtl/pidc_csr.sv
// ----------------------------------------------------------------------------
// pidc_csr: configuration registers
// Gains and term bounds behind a 64-bit APB-style port.
// ----------------------------------------------------------------------------
module pidc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [5:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready,
   output pidc_pkg::cfg_type cfg
);
   import pidc_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[5:3];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp    <= '0;
         cfg_ff.ki    <= '0;
         cfg_ff.kd    <= '0;
         cfg_ff.p_lim <= LimReset;
         cfg_ff.a_lim <= LimReset;
         cfg_ff.i_lim <= LimReset;
         cfg_ff.d_lim <= LimReset;
      end else if (wr_en) begin
         unique case (idx)
            REG_PROP_GAIN:    cfg_ff.kp    <= csr_pwdata[31:0];
            REG_INTEG_GAIN:   cfg_ff.ki    <= csr_pwdata[31:0];
            REG_DERIV_GAIN:   cfg_ff.kd    <= csr_pwdata[31:0];
            REG_P_LIMITS:     cfg_ff.p_lim <= csr_pwdata;
            REG_ACCUM_LIMITS: cfg_ff.a_lim <= csr_pwdata;
            REG_I_LIMITS:     cfg_ff.i_lim <= csr_pwdata;
            REG_D_LIMITS:     cfg_ff.d_lim <= csr_pwdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PROP_GAIN:    csr_prdata = {32'b0, cfg_ff.kp};
         REG_INTEG_GAIN:   csr_prdata = {32'b0, cfg_ff.ki};
         REG_DERIV_GAIN:   csr_prdata = {32'b0, cfg_ff.kd};
         REG_P_LIMITS:     csr_prdata = cfg_ff.p_lim;
         REG_ACCUM_LIMITS: csr_prdata = cfg_ff.a_lim;
         REG_I_LIMITS:     csr_prdata = cfg_ff.i_lim;
         REG_D_LIMITS:     csr_prdata = cfg_ff.d_lim;
         default:          csr_prdata = '0;
      endcase
   end

endmodule

FILE: hw/rtl/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div: iterative unsigned divider
// 64-bit dividend by 32-bit divisor, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pidc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [63:0] quotient,
   output logic        rem_nonzero,
   output logic        busy,
   output logic        done
);
   import pidc_pkg::*;

   logic [32:0]            rem_ff, rem_in;
   logic [63:0]            quo_ff, quo_in;
   logic [31:0]            dsr_ff;
   logic [DivCntWidth-1:0] cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;

   assign quotient    = quo_ff;
   assign rem_nonzero = (rem_ff != '0);
   assign busy        = busy_ff;
   assign done        = done_ff;

   // two restoring steps: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < 2; k++) begin
         rem_in = {rem_in[31:0], quo_in[63]};
         quo_in = {quo_in[62:0], 1'b0};
         if (rem_in >= {1'b0, dsr_ff}) begin
            rem_in    = rem_in - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DivCntWidth'(DivSteps - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

FILE: hw/rtl/pidc_dp.sv
// ----------------------------------------------------------------------------
// pidc_dp: PID datapath
// Shared 33x33 multiplier, term clamps, integrator and error state, result
// register.
// ----------------------------------------------------------------------------
module pidc_dp (
   input  logic              clock,
   input  logic              reset,
   input  pidc_pkg::op_type  op,
   input  pidc_pkg::cfg_type cfg,
   input  logic [31:0]       feedback_value,
   input  logic [31:0]       target_value,
   input  logic [31:0]       time_step,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [31:0]       drive_value,
   output logic              dt_zero,
   output logic              out_free,
   output logic              div_start,
   output logic [63:0]       div_dividend,
   output logic [31:0]       div_divisor,
   input  logic [63:0]       div_quotient,
   input  logic              div_rem_nonzero
);
   import pidc_pkg::*;

   logic [31:0]        fb_ff, tg_ff, dt_ff;
   logic [31:0]        err_ff;
   logic [32:0]        diff_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        a_lo_ff;
   logic [63:0]        acc_ff;
   logic [31:0]        p_ff, i_ff, d_ff;
   logic               neg_ff;
   logic [31:0]        drive_ff;
   logic               valid_ff;
   logic [31:0]        integ_ff;
   logic [31:0]        prev_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_res;
   logic [32:0]        err_wide;
   logic [31:0]        err_in;
   logic [63:0]        inc_in;
   logic [63:0]        integ_sum;
   logic [63:0]        d_quot;
   logic signed [33:0] out_sum;
   logic [31:0]        drive_in;

   assign rsp_tvalid   = valid_ff;
   assign drive_value  = drive_ff;
   assign dt_zero      = (dt_ff == '0);
   assign out_free     = !valid_ff || rsp_tready;
   assign div_start    = (op == OP_DIV_START);
   assign div_divisor  = dt_ff;
   assign div_dividend = prod_ff[63] ? (~prod_ff + 64'd1) : prod_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_MUL_P: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {cfg.kp[31], cfg.kp};
         end
         OP_MUL_EKI: begin
            mul_a = {err_ff[31], err_ff};
            mul_b = {cfg.ki[31], cfg.ki};
         end
         OP_MUL_HI: begin
            mul_a = {prod_ff[63], prod_ff[63:32]};
            mul_b = {1'b0, dt_ff};
         end
         OP_MUL_LO: begin
            mul_a = {1'b0, a_lo_ff};
            mul_b = {1'b0, dt_ff};
         end
         OP_MUL_I: begin
            mul_a = {integ_ff[31], integ_ff};
            mul_b = {cfg.ki[31], cfg.ki};
         end
         OP_MUL_D: begin
            mul_a = diff_ff;
            mul_b = {cfg.kd[31], cfg.kd};
         end
         default: ;
      endcase
   end

   assign mul_res = mul_a * mul_b;

   // error saturated to 32 bits
   assign err_wide = {fb_ff[31], fb_ff} - {tg_ff[31], tg_ff};
   always_comb begin
      if (err_wide[32] != err_wide[31]) begin
         err_in = err_wide[32] ? Int32Min : Int32Max;
      end else begin
         err_in = err_wide[31:0];
      end
   end

   // low half of err*ki times dt contributes only its top 32 bits
   assign inc_in    = acc_ff + {32'b0, prod_ff[63:32]};
   assign integ_sum = {{32{integ_ff[31]}}, integ_ff} + acc_ff;

   // floor on a negative quotient: one less when a remainder is left
   always_comb begin
      if (!neg_ff) begin
         d_quot = div_quotient;
      end else if (div_rem_nonzero) begin
         d_quot = ~div_quotient;
      end else begin
         d_quot = ~div_quotient + 64'd1;
      end
   end

   assign out_sum = {{2{p_ff[31]}}, p_ff} + {{2{i_ff[31]}}, i_ff}
                  + {{2{d_ff[31]}}, d_ff};
   always_comb begin
      if (out_sum > 34'sh0_7FFF_FFFF) begin
         drive_in = Int32Max;
      end else if (out_sum < -34'sh0_8000_0000) begin
         drive_in = Int32Min;
      end else begin
         drive_in = out_sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (op == OP_INTEG) begin
            integ_ff <= clamp_lim(integ_sum, cfg.a_lim);
         end
         if (op == OP_D_FIX) begin
            prev_ff <= err_ff;
         end
         if (op == OP_SUM) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            fb_ff <= feedback_value;
            tg_ff <= target_value;
            dt_ff <= time_step;
         end
         OP_ERR: err_ff <= err_in;
         OP_MUL_P: begin
            prod_ff <= mul_res[63:0];
            diff_ff <= {err_ff[31], err_ff} - {prev_ff[31], prev_ff};
         end
         OP_MUL_EKI: begin
            p_ff    <= clamp_lim({{16{prod_ff[63]}}, prod_ff[63:16]}, cfg.p_lim);
            prod_ff <= mul_res[63:0];
         end
         OP_MUL_HI: begin
            a_lo_ff <= prod_ff[31:0];
            prod_ff <= mul_res[63:0];
         end
         OP_MUL_LO: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_res[63:0];
         end
         OP_INC: acc_ff <= inc_in;
         OP_MUL_I: prod_ff <= mul_res[63:0];
         OP_CLAMP_I: begin
            i_ff <= clamp_lim({{16{prod_ff[63]}}, prod_ff[63:16]}, cfg.i_lim);
         end
         OP_MUL_D: prod_ff <= mul_res[63:0];
         OP_DIV_START: neg_ff <= prod_ff[63];
         OP_D_FIX: d_ff <= clamp_lim(d_quot, cfg.d_lim);
         OP_D_ZERO: d_ff <= '0;
         OP_SUM: drive_ff <= drive_in;
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl: PID sequencer
// Steps the datapath through error, P, integrator, I and D phases per item.
// ----------------------------------------------------------------------------
module pidc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pidc_pkg::status_type stat,
   output pidc_pkg::op_type     op
);
   import pidc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            op       = OP_ERR;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            op       = OP_MUL_P;
            state_in = ST_MUL_EKI;
         end
         ST_MUL_EKI: begin
            op       = OP_MUL_EKI;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            op       = OP_MUL_HI;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            op       = OP_MUL_LO;
            state_in = ST_INC;
         end
         ST_INC: begin
            op       = OP_INC;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            op       = OP_INTEG;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            op       = OP_MUL_I;
            state_in = ST_CLAMP_I;
         end
         ST_CLAMP_I: begin
            op       = OP_CLAMP_I;
            state_in = stat.dt_zero ? ST_D_ZERO : ST_MUL_D;
         end
         ST_MUL_D: begin
            op       = OP_MUL_D;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            op       = OP_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               op       = OP_D_FIX;
               state_in = ST_SUM;
            end
         end
         ST_D_ZERO: begin
            op       = OP_D_ZERO;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (stat.out_free) begin
               op       = OP_SUM;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped: clamped PID controller, signed Q16.16
// Items are handled one at a time: one shared 33x33 multiplier serves every
// term, and the D term waits on the iterative divide by time_step, which a
// zero time_step skips.
// Reset (synchronous, active high) clears the integrator, the stored error,
// the gains to zero and every bound pair to the full signed 32-bit range.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] feedback_value, [63:32] target_value,
                                    // [95:64] time_step
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] drive_value
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import pidc_pkg::*;

   cfg_type     cfg;
   op_type      op;
   status_type  stat;
   logic        dt_zero;
   logic        out_free;
   logic        div_start;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic [63:0] div_quotient;
   logic        div_rem_nonzero;
   logic        div_busy;
   logic        div_done;

   // gains and bounds; the user must write them only while no item is in flight, the block does not enforce this
   pidc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // status back to the sequencer
   assign stat.dt_zero  = dt_zero;
   assign stat.div_done = div_done;
   assign stat.out_free = out_free;

   // one item at a time; the next is taken as soon as the result is parked
   // in the output register, even if the sink has not taken it yet
   pidc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   // arithmetic: error, P term, integrator update, I term, D numerator,
   // floor correction of the quotient and the saturated output sum
   pidc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .cfg             (cfg),
      .feedback_value  (req_tdata[31:0]),
      .target_value    (req_tdata[63:32]),
      .time_step       (req_tdata[95:64]),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .drive_value     (rsp_tdata),
      .dt_zero         (dt_zero),
      .out_free        (out_free),
      .div_start       (div_start),
      .div_dividend    (div_dividend),
      .div_divisor     (div_divisor),
      .div_quotient    (div_quotient),
      .div_rem_nonzero (div_rem_nonzero)
   );

   // magnitude of (err - previous error) * kd divided by time_step
   pidc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor     (div_divisor),
      .quotient    (div_quotient),
      .rem_nonzero (div_rem_nonzero),
      .busy        (div_busy),
      .done        (div_done)
   );

   // a result appears only through the sum step of the sequencer
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(op == OP_SUM))
      else $error("rsp_tvalid rose without a sum step");

   // the divider is never restarted mid-run
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // no new item while a divide is still running
   a_accept_div_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !div_busy)
      else $error("item accepted during a divide");

   // completion follows a run of the divider
   a_div_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_done |-> $past(div_busy))
      else $error("divider done without a run");

endmodule

FILE: test/pid_controller_clamped_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_checker: result predictor and scoreboard
// Snoops register writes and accepted input items, predicts each drive_value
// with exact wide arithmetic and compares it with the next accepted result.
// ----------------------------------------------------------------------------
module pid_controller_clamped_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] feedback_value, [63:32] target_value,
                                    // [95:64] time_step
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] drive_value
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          outstanding
);
   import pidc_pkg::*;

   typedef logic signed [127:0] wide_type;

   logic [31:0] kp;
   logic [31:0] ki;
   logic [31:0] kd;
   logic [63:0] p_lim;
   logic [63:0] a_lim;
   logic [63:0] i_lim;
   logic [63:0] d_lim;
   wide_type    integ;
   wide_type    prev_err;

   logic [31:0] drive_fifo[$];
   logic [31:0] want;
   int          fail_count;

   // below min gives min, otherwise above max gives max
   function automatic wide_type clamp_to(input wide_type x, input logic [63:0] lim);
      wide_type mn;
      wide_type mx;
      mn = $signed(lim[31:0]);
      mx = $signed(lim[63:32]);
      if (x < mn) return mn;
      if (x > mx) return mx;
      return x;
   endfunction

   // advance integrator and (for a nonzero time step) stored error, return the expected drive_value
   function automatic logic [31:0] next_drive(input logic [31:0] fb, input logic [31:0] tg,
                                              input logic [31:0] tstep);
      wide_type fbw, tgw, dtw, kpw, kiw, kdw;
      wide_type err, p_term, i_term, d_term, num, quot, sum;
      fbw = $signed(fb);
      tgw = $signed(tg);
      dtw = {96'd0, tstep};
      kpw = $signed(kp);
      kiw = $signed(ki);
      kdw = $signed(kd);
      err = clamp_to(fbw - tgw, LimReset);
      p_term = clamp_to((err * kpw) >>> 16, p_lim);
      integ = clamp_to(integ + ((err * kiw * dtw) >>> 32), a_lim);
      i_term = clamp_to((integ * kiw) >>> 16, i_lim);
      d_term = 0;
      if (tstep != 0) begin
         num = (err - prev_err) * kdw;
         quot = num / dtw;
         if ((num % dtw) != 0 && num < 0) quot = quot - 1;
         d_term = clamp_to(quot, d_lim);
         prev_err = err;
      end
      sum = clamp_to(p_term + i_term + d_term, LimReset);
      return sum[31:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp = '0;
         ki = '0;
         kd = '0;
         p_lim = LimReset;
         a_lim = LimReset;
         i_lim = LimReset;
         d_lim = LimReset;
         integ = 0;
         prev_err = 0;
         drive_fifo.delete();
         fail_count = 0;
      end else begin
         // compare first so a result can never match the item accepted with it
         if (rsp_tvalid && rsp_tready) begin
            if (drive_fifo.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected drive_value, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = drive_fifo.pop_front();
               if (rsp_tdata !== want) begin
                  fail_count++;
                  $display("%0t: drive_value mismatch, expected %h, got %h",
                           $time, want, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready)
            drive_fifo.push_back(next_drive(req_tdata[31:0], req_tdata[63:32],
                                            req_tdata[95:64]));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               REG_PROP_GAIN:    kp = csr_pwdata[31:0];
               REG_INTEG_GAIN:   ki = csr_pwdata[31:0];
               REG_DERIV_GAIN:   kd = csr_pwdata[31:0];
               REG_P_LIMITS:     p_lim = csr_pwdata;
               REG_ACCUM_LIMITS: a_lim = csr_pwdata;
               REG_I_LIMITS:     i_lim = csr_pwdata;
               REG_D_LIMITS:     d_lim = csr_pwdata;
               default: ;
            endcase
         end
      end
      failures <= fail_count;
      outstanding <= drive_fifo.size();
   end

endmodule

FILE: test/pid_controller_clamped_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_test: stimulus and verdict for the clamped PID block
// Runs directed corner items, then random phases of register settings and
// items (closed-loop style tracking runs and noise) with random stalls on both
// streams. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module pid_controller_clamped_test;
   import pidc_pkg::*;

   localparam int          ItemTarget    = 1050;
   localparam int          WatchdogLimit = 4000;
   localparam int          SettleCycles  = 8;
   localparam int          DrainCycles   = 60;
   localparam logic [2:0]  REG_UNUSED    = 3'd7;  // no register behind this index

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata   = '0;  // [31:0] feedback_value, [63:32] target_value,
                                   // [95:64] time_step
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] drive_value
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [5:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int outstanding;
   int items_sent  = 0;
   int idle_cycles = 0;
   int stall_left  = 0;
   bit quiet_tx    = 1'b0;
   bit quiet_rx    = 1'b0;

   pid_controller_clamped DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pid_controller_clamped_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Random value sources
   // ---------------------------------------------------------------------------

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 75) return $urandom_range(1, 4);
      if (r < 95) return $urandom_range(5, 50);
      return $urandom_range(60, 200);
   endfunction

   // signed Q16.16: small, moderate, full range and the extremes
   function automatic logic [31:0] rand_q16();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      if (r < 60) return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      if (r < 90) return $urandom();
      case ($urandom_range(0, 3))
         0:       return Int32Max;
         1:       return Int32Min;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // unsigned Q16.16 seconds; zero skips the derivative path
   function automatic logic [31:0] rand_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h0000_0000;
      if (r < 50) return $urandom_range(1, 32'h0001_0000);
      if (r < 70) return $urandom();
      if (r < 80) return 32'h0000_0001;
      if (r < 88) return 32'hFFFF_FFFF;
      return $urandom_range(32'h0001_0000, 32'h0010_0000);
   endfunction

   function automatic logic [31:0] rand_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h0000_0000;
      if (r < 45) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      if (r < 65) return $urandom();
      if (r < 75) return Int32Max;
      if (r < 85) return Int32Min;
      return ($urandom_range(0, 1) == 0) ? 32'h0001_0000 : 32'hFFFF_0000;
   endfunction

   // bound pair packed as {max, min}; ordered, narrow, inverted or degenerate
   function automatic logic [63:0] rand_limits();
      int          r;
      logic [31:0] lo;
      logic [31:0] span;
      r = $urandom_range(0, 99);
      lo = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      span = $urandom_range(0, 32'h0100_0000);
      if (r < 20) return LimReset;
      if (r < 50) return {lo + span, lo};
      if (r < 65) return {$urandom(), $urandom()};
      if (r < 75) return {span >> 4, -(span >> 4)};
      if (r < 85) return {lo, lo + span + 1};
      if (r < 92) return {lo, lo};
      return ($urandom_range(0, 1) == 0) ? {Int32Min, Int32Max} : {Int32Max, Int32Max};
   endfunction

   // ---------------------------------------------------------------------------
   // Bus drivers
   // ---------------------------------------------------------------------------

   // setup phase, access phase, then a return to idle so writes never abut
   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // hold tvalid across items sent back to back, drop it only for a real gap
   task automatic send_item(input logic [31:0] fb, input logic [31:0] tg,
                            input logic [31:0] tstep);
      int gap;
      gap = quiet_tx ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {tstep, tg, fb};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every predicted result; the first edge lets the
   // checker count the item accepted at this edge
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls, with quiet stretches of full throughput
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if ($urandom_range(0, 399) == 0) quiet_rx <= !quiet_rx;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet_rx && $urandom_range(0, 99) < 25) stall_left <= 1 + idle_gap();
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on any port for too long
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      bit          all_regs;
      bit          tracking;
      int          phase_len;
      logic [31:0] setpoint;
      logic [31:0] level;
      logic [31:0] base_step;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: all gains zero, so every drive_value is zero
      send_item(Int32Max, Int32Min, 32'h0001_0000);
      send_item(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);

      // unit-range gains, full bounds: saturated error both ways, zero step
      settle();
      csr_write(REG_PROP_GAIN, 64'h0000_0000_0001_0000);
      csr_write(REG_INTEG_GAIN, 64'h0000_0000_0000_8000);
      csr_write(REG_DERIV_GAIN, 64'h0000_0000_0000_4000);
      send_item(Int32Max, Int32Min, 32'h0000_0001);
      send_item(Int32Min, Int32Max, 32'hFFFF_FFFF);
      send_item(32'h0003_0000, 32'h0001_0000, 32'h0000_0000);
      send_item(32'h0003_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(32'h1234_5678, 32'h1234_5678, 32'h0001_0000);
      send_item(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);

      // extreme gains, narrow P and integrator bounds, inverted D bounds
      settle();
      csr_write(REG_PROP_GAIN, {32'hFFFF_FFFF, Int32Max});
      csr_write(REG_INTEG_GAIN, {32'h0000_0000, Int32Min});
      csr_write(REG_DERIV_GAIN, {32'hA5A5_A5A5, Int32Max});
      csr_write(REG_P_LIMITS, 64'h0001_0000_FFFF_0000);
      csr_write(REG_ACCUM_LIMITS, 64'h0010_0000_FFF0_0000);
      csr_write(REG_D_LIMITS, 64'hFFFF_0000_0001_0000);
      send_item(32'h0002_0000, 32'h0000_0000, 32'h0001_0000);
      send_item(32'h0000_0000, 32'h0002_0000, 32'h0000_8000);
      send_item(32'h0000_0000, 32'h0002_0000, 32'h0000_0000);
      send_item(Int32Max, Int32Min, 32'h0000_0001);
      send_item(Int32Min, 32'h0000_0001, 32'h0000_0000);
      send_item(32'h0000_0100, 32'h0000_0000, 32'h0002_0000);

      // degenerate bound pairs and a write to an index with no register
      settle();
      csr_write(REG_PROP_GAIN, {32'h0000_0000, Int32Min});
      csr_write(REG_P_LIMITS, {Int32Max, Int32Max});
      csr_write(REG_ACCUM_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_I_LIMITS, 64'h0000_0000_0000_0000);
      csr_write(REG_D_LIMITS, {Int32Min, Int32Min});
      csr_write(REG_UNUSED, 64'hDEAD_BEEF_CAFE_F00D);
      send_item(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0000);
      send_item(Int32Min, Int32Max, 32'h0000_0001);
      send_item(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(Int32Max, 32'h0000_0000, 32'h0001_0000);
      send_item(32'hFFFF_0000, 32'h0001_0000, 32'h0000_4000);

      // random phases: drain, retune while idle, then a burst of items
      all_regs = 1'b1;
      while (items_sent < ItemTarget) begin
         settle();
         if (all_regs || $urandom_range(0, 1) == 1)
            csr_write(REG_PROP_GAIN, {$urandom(), rand_gain()});
         if (all_regs || $urandom_range(0, 1) == 1)
            csr_write(REG_INTEG_GAIN, {$urandom(), rand_gain()});
         if (all_regs || $urandom_range(0, 1) == 1)
            csr_write(REG_DERIV_GAIN, {$urandom(), rand_gain()});
         if (all_regs || $urandom_range(0, 1) == 1) csr_write(REG_P_LIMITS, rand_limits());
         if (all_regs || $urandom_range(0, 1) == 1) csr_write(REG_ACCUM_LIMITS, rand_limits());
         if (all_regs || $urandom_range(0, 1) == 1) csr_write(REG_I_LIMITS, rand_limits());
         if (all_regs || $urandom_range(0, 1) == 1) csr_write(REG_D_LIMITS, rand_limits());
         if ($urandom_range(0, 9) == 0) csr_write(REG_UNUSED, {$urandom(), $urandom()});
         all_regs = 1'b0;

         quiet_tx = ($urandom_range(0, 4) == 0);
         phase_len = $urandom_range(20, 90);
         tracking = ($urandom_range(0, 99) < 60);
         setpoint = rand_q16();
         level = rand_q16();
         base_step = rand_step();
         repeat (phase_len) begin
            if (tracking) begin
               // control-loop run: fixed setpoint, drifting measurement, mostly steady step
               level = level + ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
               send_item(level, setpoint,
                         ($urandom_range(0, 9) == 0) ? rand_step() : base_step);
            end else begin
               send_item(rand_q16(), rand_q16(), rand_step());
            end
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: pid_controller_clamped.f
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_csr.sv
hw/rtl/pidc_div.sv
hw/rtl/pidc_dp.sv
hw/rtl/pidc_ctrl.sv
hw/rtl/pid_controller_clamped.sv
test/pid_controller_clamped_checker.sv
test/pid_controller_clamped_test.sv
